// ===== design/swr_pkg.sv =====
// Shared types and constants of the stop-and-wait receiver.
package swr_pkg;

   // Packet geometry
   localparam int PAYLOAD_BYTES = 1400;
   localparam int HEADER_WORDS  = 4;

   // Field widths
   localparam int WORD_W  = 16;
   localparam int SEQ_W   = 16;
   localparam int INDEX_W = 10;
   localparam int LEN_W   = 11;

   localparam logic [INDEX_W-1:0] INDEX_MAX  = {INDEX_W{1'b1}};
   localparam logic [INDEX_W-1:0] HDR_INDEX  = INDEX_W'(HEADER_WORDS);
   localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(PAYLOAD_BYTES);
   localparam logic [WORD_W-1:0]  SUM_GOOD   = {WORD_W{1'b1}};
   localparam logic [SEQ_W-1:0]   SEQ_FINAL  = {SEQ_W{1'b1}};
   localparam logic [SEQ_W-1:0]   SEQ_DIR    = '0;

   // Packet verdict codes
   typedef enum logic [2:0] {
      VERDICT_CORRUPT  = 3'd0,
      VERDICT_NO_DIR   = 3'd1,
      VERDICT_DIR      = 3'd2,
      VERDICT_IN_ORDER = 3'd3,
      VERDICT_DUP      = 3'd4,
      VERDICT_FINAL    = 3'd5,
      VERDICT_IGNORED  = 3'd6,
      VERDICT_HALTED   = 3'd7
   } verdict_type;

   // Control from the top level to the packet accumulator
   typedef struct packed {
      logic step;   // a word moves through this cycle
      logic last;   // that word closes the packet
   } acc_ctrl_type;

   // Packet totals including the current word
   typedef struct packed {
      logic [WORD_W-1:0] sum;
      logic [LEN_W-1:0]  length;
   } acc_result_type;

endpackage

// ===== design/stop_and_wait_receiver_unit.sv =====
// Stop-and-wait receiver: packet checksum, sequence tracking and ack decision.
// A packet's last word is taken into the input register; its verdict is held in the result register, which drives rsp.
// Throughput: one word per cycle; input register, one pass of logic, result register.
// A waiting verdict does not block the input; words stall only if a second verdict
// is due while the first is still held.
// Reset (synchronous, active high) clears the packet sums, sequence state and halt.
module stop_and_wait_receiver_unit
   import swr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] word, [31:16] seq_num
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] send_ack, [16:1] ack_value, [17] write_payload,
                                    // [28:18] payload_length, [31:29] zero
   output logic [2:0]  rsp_tuser    // verdict
);

   // Input register
   logic              in_valid_ff;
   logic [WORD_W-1:0] in_word_ff;
   logic [SEQ_W-1:0]  in_seq_ff;
   logic              in_last_ff;

   // Session state
   logic              dir_seen_ff,     dir_seen_in;
   logic [SEQ_W-1:0]  expected_seq_ff, expected_seq_in;
   logic              halted_ff,       halted_in;

   // Result register
   logic              rsp_valid_ff;
   verdict_type       verdict_ff,      verdict_in;
   logic              send_ack_ff,     send_ack_in;
   logic [SEQ_W-1:0]  ack_value_ff,    ack_value_in;
   logic              write_ff,        write_in;
   logic [LEN_W-1:0]  length_ff,       length_in;

   logic              out_free;
   logic              advance;
   logic              close_pkt;
   logic [SEQ_W-1:0]  seq_plus;
   acc_ctrl_type      acc_ctrl;
   acc_result_type    acc_res;

   // Handshake: a word moves on unless it closes a packet and the result is full
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign close_pkt  = advance && in_last_ff;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff <= req_tdata[15:0];
         in_seq_ff  <= req_tdata[31:16];
         in_last_ff <= req_tlast;
      end
   end

   // Checksum and byte count
   assign acc_ctrl.step = advance && !halted_ff;
   assign acc_ctrl.last = in_last_ff;

   swr_pkt_acc u_acc (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (acc_ctrl),
      .word   (in_word_ff),
      .result (acc_res)
   );

   // Decide the verdict for a closing word
   always_comb begin
      seq_plus        = in_seq_ff + SEQ_W'(1);
      dir_seen_in     = dir_seen_ff;
      expected_seq_in = expected_seq_ff;
      halted_in       = halted_ff;
      verdict_in      = VERDICT_IGNORED;
      send_ack_in     = 1'b0;
      ack_value_in    = '0;
      write_in        = 1'b0;
      length_in       = '0;
      if (halted_ff) begin
         verdict_in = VERDICT_HALTED;
      end else if (acc_res.sum != SUM_GOOD) begin
         verdict_in = VERDICT_CORRUPT;
      end else if (!dir_seen_ff) begin
         if (in_seq_ff != SEQ_DIR) begin
            verdict_in = VERDICT_NO_DIR;
         end else begin
            verdict_in      = VERDICT_DIR;
            send_ack_in     = 1'b1;
            dir_seen_in     = 1'b1;
            expected_seq_in = expected_seq_ff + SEQ_W'(1);
         end
      end else if (in_seq_ff == SEQ_FINAL) begin
         verdict_in   = VERDICT_FINAL;
         send_ack_in  = 1'b1;
         ack_value_in = SEQ_FINAL;
         halted_in    = 1'b1;
      end else if (in_seq_ff == expected_seq_ff) begin
         verdict_in      = VERDICT_IN_ORDER;
         send_ack_in     = 1'b1;
         ack_value_in    = in_seq_ff;
         write_in        = 1'b1;
         length_in       = acc_res.length;
         expected_seq_in = expected_seq_ff + SEQ_W'(1);
      end else if (seq_plus == expected_seq_ff) begin
         verdict_in   = VERDICT_DUP;
         send_ack_in  = 1'b1;
         ack_value_in = in_seq_ff;
      end
   end

   // Commit session state on a closing word
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_seen_ff     <= 1'b0;
         expected_seq_ff <= '0;
         halted_ff       <= 1'b0;
      end else if (close_pkt) begin
         dir_seen_ff     <= dir_seen_in;
         expected_seq_ff <= expected_seq_in;
         halted_ff       <= halted_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (close_pkt) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (close_pkt) begin
         verdict_ff   <= verdict_in;
         send_ack_ff  <= send_ack_in;
         ack_value_ff <= ack_value_in;
         write_ff     <= write_in;
         length_ff    <= length_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = verdict_ff;
   assign rsp_tdata  = {3'b000, length_ff, write_ff, ack_value_ff, send_ack_ff};

endmodule

// ===== design/swr_pkt_acc.sv =====
// Per-packet accumulator: ones' complement sum and payload byte count.
module swr_pkt_acc
   import swr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  acc_ctrl_type        ctrl,
   input  logic [WORD_W-1:0]   word,
   output acc_result_type      result
);

   logic [WORD_W-1:0]  ones_sum_ff,     ones_sum_in;
   logic [INDEX_W-1:0] word_index_ff,   word_index_in;
   logic [LEN_W-1:0]   length_count_ff, length_count_in;
   logic               zero_seen_ff,    zero_seen_in;

   logic [WORD_W:0]    sum_wide;
   logic [WORD_W-1:0]  sum_fold;
   logic               in_payload;
   logic               zero_mid;
   logic [LEN_W-1:0]   len_mid;
   logic [LEN_W-1:0]   len_end;
   logic               zero_end;

   // Fold the end-around carry back into the sum
   always_comb begin
      sum_wide = {1'b0, ones_sum_ff} + {1'b0, word};
      sum_fold = sum_wide[WORD_W] ? (sum_wide[WORD_W-1:0] + WORD_W'(1))
                                  : sum_wide[WORD_W-1:0];
   end

   // Scan the low byte, then the high byte, up to the first zero byte
   always_comb begin
      in_payload = (word_index_ff >= HDR_INDEX);
      zero_mid   = zero_seen_ff;
      len_mid    = length_count_ff;
      if (in_payload && !zero_seen_ff) begin
         if (word[7:0] == 8'd0) begin
            zero_mid = 1'b1;
         end else if (length_count_ff < LEN_MAX) begin
            len_mid = length_count_ff + LEN_W'(1);
         end
      end
      zero_end = zero_mid;
      len_end  = len_mid;
      if (in_payload && !zero_mid) begin
         if (word[15:8] == 8'd0) begin
            zero_end = 1'b1;
         end else if (len_mid < LEN_MAX) begin
            len_end = len_mid + LEN_W'(1);
         end
      end
   end

   // Advance or clear at the end of a packet
   always_comb begin
      ones_sum_in     = ones_sum_ff;
      word_index_in   = word_index_ff;
      length_count_in = length_count_ff;
      zero_seen_in    = zero_seen_ff;
      if (ctrl.step) begin
         if (ctrl.last) begin
            ones_sum_in     = '0;
            word_index_in   = '0;
            length_count_in = '0;
            zero_seen_in    = 1'b0;
         end else begin
            ones_sum_in     = sum_fold;
            word_index_in   = (word_index_ff < INDEX_MAX) ? word_index_ff + INDEX_W'(1)
                                                          : word_index_ff;
            length_count_in = len_end;
            zero_seen_in    = zero_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_sum_ff     <= '0;
         word_index_ff   <= '0;
         length_count_ff <= '0;
         zero_seen_ff    <= 1'b0;
      end else begin
         ones_sum_ff     <= ones_sum_in;
         word_index_ff   <= word_index_in;
         length_count_ff <= length_count_in;
         zero_seen_ff    <= zero_seen_in;
      end
   end

   assign result.sum    = sum_fold;
   assign result.length = len_end;

endmodule

// ===== design/swr_checker.sv =====
// Port checker for the stop-and-wait receiver, bound to the top level.
module swr_checker
   import swr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // Hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // Ack value only with an ack
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[16:1] == 16'd0)
      else $error("ack value without ack");

   // Payload commit only for in-order packets, length zero otherwise
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17] == (rsp_tuser == VERDICT_IN_ORDER))
                     && (rsp_tdata[17] || rsp_tdata[28:18] == 11'd0))
      else $error("payload commit does not match verdict");

   // A result word right after a delivered final must be halted, with all fields zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == VERDICT_FINAL
      |=> !rsp_tvalid || (rsp_tuser == VERDICT_HALTED && rsp_tdata == 32'd0))
      else $error("verdict after final is not halted");

   // Length never exceeds the payload size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[28:18] <= LEN_MAX)
      else $error("payload length beyond payload size");

endmodule

bind stop_and_wait_receiver_unit swr_checker u_swr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== dv/stop_and_wait_receiver_unit_tb.sv =====
// Testbench for the stop-and-wait receiver: directed and random packets scored by a predictor.
`timescale 1ns / 100ps

module stop_and_wait_receiver_unit_tb;
   import swr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 400;
   localparam int QUIET_AFTER  = 330;
   localparam int DRAIN_LIMIT  = 2000;

   // One packet decision as it shows on the result channel
   typedef struct packed {
      verdict_type       verdict;
      logic              ack_sent;
      logic [SEQ_W-1:0]  ack_seq;
      logic              commit;
      logic [LEN_W-1:0]  commit_len;
   } ack_decision_type;

   // One row of the directed stimulus
   typedef struct {
      logic [WORD_W-1:0] word;
      logic [SEQ_W-1:0]  seq;
      logic              last;
      bit                typed;
      ack_decision_type  want;
   } stim_row_type;

   typedef enum int {PK_IN_ORDER, PK_DUP, PK_STRAY, PK_CORRUPT, PK_NOISE} pkt_kind_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [15:0] word, [31:16] seq_num
   logic        req_tlast;    // last_word
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [0] send_ack, [16:1] ack_value, [17] write_payload,
                              // [28:18] payload_length, [31:29] zero
   logic [2:0]  rsp_tuser;    // verdict

   // Receiver state as the predictor sees it
   logic [WORD_W-1:0]  run_sum;
   logic [INDEX_W-1:0] word_pos;
   logic [LEN_W-1:0]   byte_count;
   bit                 zero_hit;
   bit                 dir_ok;
   logic [SEQ_W-1:0]   next_seq;
   bit                 stopped;

   ack_decision_type pending_verdicts[$];
   stim_row_type     stim_rows[$];
   int               verdict_hits[8];
   int               fail_count;
   int               words_sent;
   int               cycle_count;
   bit               idle_on;

   stop_and_wait_receiver_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End-around-carry add of one word into a ones' complement sum
   function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
      logic [WORD_W:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
   endfunction

   // Advance the receiver state by one word; on a last word produce the decision
   task automatic track_word(input logic [WORD_W-1:0] w, input logic [SEQ_W-1:0] s,
                             input logic l, output bit made, output ack_decision_type d);
      logic [7:0] b;
      made = 1'b0;
      d = '0;
      if (stopped) begin
         if (l) begin
            made = 1'b1;
            d.verdict = VERDICT_HALTED;
         end
         return;
      end
      run_sum = ones_add(run_sum, w);
      // scan payload bytes, low byte first, up to the first zero byte
      if (word_pos >= HDR_INDEX) begin
         for (int k = 0; k < 2; k++) begin
            b = w[8*k +: 8];
            if (!zero_hit) begin
               if (b == 8'd0) zero_hit = 1'b1;
               else if (byte_count < LEN_MAX) byte_count++;
            end
         end
      end
      if (word_pos < INDEX_MAX) word_pos++;
      if (!l) return;
      made = 1'b1;
      if (run_sum != SUM_GOOD) begin
         d.verdict = VERDICT_CORRUPT;
      end else if (!dir_ok) begin
         if (s != SEQ_DIR) begin
            d.verdict = VERDICT_NO_DIR;
         end else begin
            d.verdict  = VERDICT_DIR;
            d.ack_sent = 1'b1;
            d.ack_seq  = SEQ_DIR;
            dir_ok     = 1'b1;
            next_seq   = next_seq + 16'd1;
         end
      end else if (s == SEQ_FINAL) begin
         d.verdict  = VERDICT_FINAL;
         d.ack_sent = 1'b1;
         d.ack_seq  = SEQ_FINAL;
         stopped    = 1'b1;
      end else if (s == next_seq) begin
         d.verdict    = VERDICT_IN_ORDER;
         d.ack_sent   = 1'b1;
         d.ack_seq    = s;
         d.commit     = 1'b1;
         d.commit_len = byte_count;
         next_seq     = next_seq + 16'd1;
      end else if (SEQ_W'(s + 16'd1) == next_seq) begin
         d.verdict  = VERDICT_DUP;
         d.ack_sent = 1'b1;
         d.ack_seq  = s;
      end else begin
         d.verdict = VERDICT_IGNORED;
      end
      run_sum    = '0;
      word_pos   = '0;
      byte_count = '0;
      zero_hit   = 1'b0;
   endtask

   // Drive one word, wait for it to be taken, then log its expected decision
   task automatic send_word(input logic [WORD_W-1:0] w, input logic [SEQ_W-1:0] s,
                            input logic l, input bit typed = 1'b0,
                            input ack_decision_type want = '0);
      bit               made;
      ack_decision_type got;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s, w};
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      track_word(w, s, l, made, got);
      if (made) pending_verdicts.push_back(typed ? want : got);
      words_sent++;
      @(negedge clock);
   endtask

   // Append one directed word; typed rows carry their decision written out
   task automatic add_row(input logic [WORD_W-1:0] w, input logic [SEQ_W-1:0] s,
                          input logic l, input bit typed = 1'b0,
                          input verdict_type v = VERDICT_CORRUPT,
                          input logic snd = 1'b0, input logic [SEQ_W-1:0] ack = '0);
      stim_row_type r;
      r.word  = w;
      r.seq   = s;
      r.last  = l;
      r.typed = typed;
      r.want  = '0;
      r.want.verdict  = v;
      r.want.ack_sent = snd;
      r.want.ack_seq  = ack;
      stim_rows.push_back(r);
   endtask

   // Build and send one packet; good packets close with the checksum word
   task automatic send_packet(input pkt_kind_type kind, input int n_words);
      logic [SEQ_W-1:0]  seq;
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] acc;
      int                flip;
      acc = '0;
      case (kind)
         PK_IN_ORDER, PK_CORRUPT: seq = next_seq;
         PK_DUP:                  seq = next_seq - 16'd1;
         default:                 seq = SEQ_W'($urandom_range(0, 16'hFFFE));
      endcase
      for (int i = 0; i < n_words - 1; i++) begin
         w = WORD_W'($urandom);
         case ($urandom_range(0, 9))
            0: w[7:0] = 8'd0;
            1: w[15:8] = 8'd0;
            2: w = '0;
            3: w = '1;
            default: ;
         endcase
         acc = ones_add(acc, w);
         send_word(w, (kind == PK_NOISE) ? SEQ_W'($urandom) : seq, 1'b0);
      end
      w = ~acc;
      if (kind == PK_CORRUPT) begin
         flip = $urandom_range(0, WORD_W - 1);
         w[flip] = ~w[flip];
      end
      if (kind == PK_NOISE) w = WORD_W'($urandom);
      send_word(w, seq, 1'b1);
   endtask

   // Hold the sender until every decision has come back, with a limit
   task automatic wait_drained();
      int waited;
      req_tvalid <= 1'b0;
      @(negedge clock);
      for (waited = 0; pending_verdicts.size() != 0 && waited < DRAIN_LIMIT; waited++)
         @(negedge clock);
   endtask

   // Stall the result channel in random bursts
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Score each result word against the oldest expected decision
   always @(posedge clock) begin : rsp_check
      ack_decision_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         verdict_hits[rsp_tuser]++;
         if (pending_verdicts.size() == 0) begin
            $error("unexpected result word: verdict %0d", rsp_tuser);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tuser !== want.verdict) begin
               $error("verdict: expected %0d, got %0d", want.verdict, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[0] !== want.ack_sent) begin
               $error("send_ack: expected %0d, got %0d", want.ack_sent, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[16:1] !== want.ack_seq) begin
               $error("ack_value: expected %0d, got %0d", want.ack_seq, rsp_tdata[16:1]);
               fail_count++;
            end
            if (rsp_tdata[17] !== want.commit) begin
               $error("write_payload: expected %0d, got %0d", want.commit, rsp_tdata[17]);
               fail_count++;
            end
            if (rsp_tdata[28:18] !== want.commit_len) begin
               $error("payload_length: expected %0d, got %0d", want.commit_len,
                      rsp_tdata[28:18]);
               fail_count++;
            end
         end
      end
   end

   // Count cycles and stop a run that hangs
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int           head_rows;
      int           short_words;
      int           packets;
      int           n;
      int           pick;
      pkt_kind_type kind;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b1;
      cycle_count = 0;
      fail_count  = 0;
      words_sent  = 0;
      idle_on     = 1'b1;
      run_sum     = '0;
      word_pos    = '0;
      byte_count  = '0;
      zero_hit    = 1'b0;
      dir_ok      = 1'b0;
      next_seq    = '0;
      stopped     = 1'b0;

      // before the directory: all-zero packet, carry fold, stray and final seq
      add_row(16'h0000, 16'h0005, 1'b1, 1'b1, VERDICT_CORRUPT);
      add_row(16'h8000, SEQ_DIR,  1'b0);
      add_row(16'h8000, SEQ_DIR,  1'b1, 1'b1, VERDICT_CORRUPT);
      add_row(16'hFFFF, 16'h0007, 1'b1, 1'b1, VERDICT_NO_DIR);
      add_row(16'hFFFF, SEQ_FINAL, 1'b1, 1'b1, VERDICT_NO_DIR);
      // directory packet
      add_row(16'hFFFF, SEQ_DIR,  1'b1, 1'b1, VERDICT_DIR, 1'b1, SEQ_DIR);
      // in-order data with a zero byte inside the payload
      add_row(16'h1234, 16'h0001, 1'b0);
      add_row(16'hEDCB, 16'h0001, 1'b0);
      add_row(16'h0000, 16'h0001, 1'b0);
      add_row(16'h0000, 16'h0001, 1'b0);
      add_row(16'h4142, 16'h0001, 1'b0);
      add_row(16'h0043, 16'h0001, 1'b0);
      add_row(16'hBE7A, 16'h0001, 1'b1);
      // a duplicate of the last data, then a repeat of the directory and a stray, both ignored
      add_row(16'hFFFF, 16'h0001, 1'b1);
      add_row(16'hFFFF, SEQ_DIR,  1'b1);
      add_row(16'hFFFF, 16'h7FFF, 1'b1);
      // header-only packet, then a bad sum after the directory
      add_row(16'h0001, 16'h0002, 1'b0);
      add_row(16'hFFFE, 16'h0002, 1'b1);
      add_row(16'hFFFE, 16'h0003, 1'b1, 1'b1, VERDICT_CORRUPT);
      head_rows = stim_rows.size();
      // final packet, then words into a halted block
      add_row(16'hFFFF, SEQ_FINAL, 1'b1, 1'b1, VERDICT_FINAL, 1'b1, SEQ_FINAL);
      add_row(16'h1234, 16'h0003, 1'b0);
      add_row(16'h0000, 16'h0003, 1'b1, 1'b1, VERDICT_HALTED);
      add_row(16'hFFFF, SEQ_FINAL, 1'b1, 1'b1, VERDICT_HALTED);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < head_rows; i++)
         send_word(stim_rows[i].word, stim_rows[i].seq, stim_rows[i].last,
                   stim_rows[i].typed, stim_rows[i].want);

      // random packets, mostly well formed
      short_words = 0;
      packets     = 0;
      while (short_words < RANDOM_WORDS) begin
         if (short_words >= QUIET_AFTER) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 55)      kind = PK_IN_ORDER;
         else if (pick < 70) kind = PK_DUP;
         else if (pick < 80) kind = PK_STRAY;
         else if (pick < 92) kind = PK_CORRUPT;
         else                kind = PK_NOISE;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         send_packet(kind, n);
         short_words += n;
         packets++;
         if (packets == 5 || packets % 25 == 0) wait_drained();
      end

      idle_on = 1'b0;
      for (int i = head_rows; i < stim_rows.size(); i++)
         send_word(stim_rows[i].word, stim_rows[i].seq, stim_rows[i].last,
                   stim_rows[i].typed, stim_rows[i].want);

      wait_drained();
      if (pending_verdicts.size() != 0) begin
         $error("%0d expected decisions never arrived", pending_verdicts.size());
         fail_count++;
      end
      repeat (8) @(negedge clock);

      $display("Covered %0d words: directed edge packets, random packets of every kind.",
               words_sent);
      $display("Decisions: corrupt %0d, no-dir %0d, dir %0d, in-order %0d,",
               verdict_hits[VERDICT_CORRUPT], verdict_hits[VERDICT_NO_DIR],
               verdict_hits[VERDICT_DIR], verdict_hits[VERDICT_IN_ORDER]);
      $display("           dup %0d, final %0d, ignored %0d, halted %0d",
               verdict_hits[VERDICT_DUP], verdict_hits[VERDICT_FINAL],
               verdict_hits[VERDICT_IGNORED], verdict_hits[VERDICT_HALTED]);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
